// ===== hdl/lfmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfmc_pkg
// Shared types and constants of the line-follow motor controller: transaction
// payloads, register map, queued command format and steering codes.
// ----------------------------------------------------------------------------
package lfmc_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_US    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_DELTA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HARD_DELTA = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POLARITY   = 3'd5;

   // Register reset values
   localparam logic [15:0] RST_PWM_PERIOD = 16'd2000;
   localparam logic [15:0] RST_TICK_US    = 16'd500;
   localparam logic [6:0]  RST_BASE_SPEED = 7'd22;
   localparam logic [6:0]  RST_SOFT_DELTA = 7'd5;
   localparam logic [6:0]  RST_HARD_DELTA = 7'd12;
   localparam logic [2:0]  RST_POLARITY   = 3'd7;

   // Polarity flag bits
   localparam int POL_LINE_HIGH = 0;
   localparam int POL_OBST_LOW  = 1;
   localparam int POL_BUZZ_HIGH = 2;

   // Input transaction modes
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_LINE = 2'd1;
   localparam logic [1:0] MODE_OBST = 2'd2;

   // Line codes {left, centre, right} after polarity
   localparam logic [2:0] CODE_LOST       = 3'b000;
   localparam logic [2:0] CODE_RIGHT_HARD = 3'b001;
   localparam logic [2:0] CODE_CENTRE     = 3'b010;
   localparam logic [2:0] CODE_RIGHT_SOFT = 3'b011;
   localparam logic [2:0] CODE_LEFT_HARD  = 3'b100;
   localparam logic [2:0] CODE_GAP        = 3'b101;
   localparam logic [2:0] CODE_LEFT_SOFT  = 3'b110;
   localparam logic [2:0] CODE_ALL        = 3'b111;

   // Steering bias
   localparam logic [1:0] BIAS_NONE  = 2'd0;
   localparam logic [1:0] BIAS_LEFT  = 2'd1;
   localparam logic [1:0] BIAS_RIGHT = 2'd2;

   localparam logic [6:0] PCT_FULL    = 7'd100;
   // {right_in2, right_in1, left_in2, left_in1}: both motors in reverse
   localparam logic [3:0] DIR_REVERSE = 4'b1010;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] mode;
      logic       line_left;
      logic       line_center;
      logic       line_right;
      logic       obstacle_left;
      logic       obstacle_right;
   } req_type;

   typedef struct packed {
      logic       left_pwm;
      logic       right_pwm;
      logic       left_in1;
      logic       left_in2;
      logic       right_in1;
      logic       right_in2;
      logic       buzzer_pin;
      logic [6:0] left_speed;
      logic [6:0] right_speed;
      logic       stop_issued;
      logic       blocked;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pwm_period_us;
      logic [15:0] tick_us;
      logic [6:0]  base_speed;
      logic [6:0]  soft_delta;
      logic [6:0]  hard_delta;
      logic [2:0]  polarity_flags;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_LINE,
      CMD_OBST,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   line_code;
      logic         obstacle;
   } cmd_type;

   // Queue output handshake towards the back
   typedef struct packed {
      logic    valid;
      cmd_type head;
   } queue_out_type;

endpackage

// ===== hdl/lfmc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfmc_front
// Accepts request transactions, applies sensor polarity and classifies each
// one into a compact command for the queue.
// ----------------------------------------------------------------------------
module lfmc_front (
   input  lfmc_pkg::req_type req_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  lfmc_pkg::cfg_type cfg,
   input  logic              queue_full,
   output logic              push,
   output lfmc_pkg::cmd_type push_data
);
   import lfmc_pkg::*;

   logic line_inv;
   logic obst_inv;

   // Stall only on a full queue
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Polarity correction
   assign line_inv = ~cfg.polarity_flags[POL_LINE_HIGH];
   assign obst_inv = cfg.polarity_flags[POL_OBST_LOW];

   // Classification
   always_comb begin
      push_data.line_code = {req_data.line_left   ^ line_inv,
                             req_data.line_center ^ line_inv,
                             req_data.line_right  ^ line_inv};
      push_data.obstacle  = (req_data.obstacle_left  ^ obst_inv) |
                            (req_data.obstacle_right ^ obst_inv);
      unique case (req_data.mode)
         MODE_TICK: push_data.kind = CMD_TICK;
         MODE_LINE: push_data.kind = CMD_LINE;
         MODE_OBST: push_data.kind = CMD_OBST;
         default:   push_data.kind = CMD_NONE;
      endcase
   end

endmodule

// ===== hdl/lfmc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfmc_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module lfmc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lfmc_pkg::cmd_type       push_data,
   output logic                    full,
   input  logic                    pop,
   output lfmc_pkg::queue_out_type q_out
);
   import lfmc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_out.valid = (count_ff != '0);
   assign q_out.head  = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/lfmc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfmc_back
// Executes queued commands: PWM phase advance with modulo unit and duty
// compare, steering from the line code, obstacle stop and buzzer, and the
// response output register.
// ----------------------------------------------------------------------------
module lfmc_back #(
   parameter int PHASE_BITS        = 16,
   parameter int BUZZ_TOGGLE_TICKS = 300
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lfmc_pkg::cfg_type       cfg,
   input  lfmc_pkg::queue_out_type q_out,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lfmc_pkg::rsp_type       rsp_data
);
   import lfmc_pkg::*;

   localparam int SUM_W  = (PHASE_BITS > 16 ? PHASE_BITS : 16) + 1;
   localparam int CNT_W  = $clog2(SUM_W);
   localparam int LOW_W  = (PHASE_BITS < 16 ? PHASE_BITS : 16);
   localparam int BUZZ_W = $clog2(BUZZ_TOGGLE_TICKS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LINE,
      S_OBST,
      S_SUM,
      S_DIV,
      S_THR,
      S_CMP,
      S_DONE
   } state_type;

   state_type              state_ff,   state_in;
   cmd_type                cmd_ff,     cmd_in;
   logic                   stop_ff,    stop_in;
   logic [PHASE_BITS-1:0]  phase_ff,   phase_in;
   logic [6:0]             duty_l_ff,  duty_l_in;
   logic [6:0]             duty_r_ff,  duty_r_in;
   logic [1:0]             bias_ff,    bias_in;
   logic                   obst_ff,    obst_in;
   logic                   alarm_ff,   alarm_in;
   logic                   blevel_ff,  blevel_in;
   logic [BUZZ_W-1:0]      bcount_ff,  bcount_in;
   logic [3:0]             dir_ff,     dir_in;
   logic [1:0]             pins_ff,    pins_in;
   logic [SUM_W-1:0]       num_ff,     num_in;
   logic [15:0]            rem_ff,     rem_in;
   logic [CNT_W-1:0]       cnt_ff,     cnt_in;
   logic [15:0]            mod_ff,     mod_in;
   logic [22:0]            prod_l_ff,  prod_l_in;
   logic [22:0]            prod_r_ff,  prod_r_in;
   logic [23:0]            lim_ff,     lim_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff,  rsp_data_in;

   logic [SUM_W-1:0]       sum;
   logic [SUM_W-1:0]       period_ext;
   logic [SUM_W-1:0]       period_x2;
   logic [16:0]            trial;
   logic [15:0]            rem_step;
   logic [15:0]            phase_lo;
   logic [BUZZ_W-1:0]      bcount_inc;
   logic signed [8:0]      base_s, soft_s, hard_s, left_s, right_s;
   logic                   slot_free;
   logic                   buzz_on;

   function automatic logic [6:0] clamp_pct(input logic signed [8:0] v);
      logic [6:0] r;
      if (v < 9'sd0) begin
         r = 7'd0;
      end else if (v > $signed({2'b00, PCT_FULL})) begin
         r = PCT_FULL;
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == S_IDLE) && q_out.valid;

   // Phase sum and one restoring modulo step
   assign sum        = SUM_W'(phase_ff) + SUM_W'(cfg.tick_us);
   assign period_ext = SUM_W'(cfg.pwm_period_us);
   assign period_x2  = SUM_W'({cfg.pwm_period_us, 1'b0});
   assign trial      = {rem_ff, num_ff[SUM_W-1]};
   assign rem_step   = (trial >= {1'b0, cfg.pwm_period_us}) ?
                       16'(trial - {1'b0, cfg.pwm_period_us}) : trial[15:0];
   assign phase_lo   = 16'(mod_ff[LOW_W-1:0]);
   assign bcount_inc = BUZZ_W'(bcount_ff + 1'b1);

   // Steering operands
   assign base_s = $signed({2'b00, cfg.base_speed});
   assign soft_s = $signed({2'b00, cfg.soft_delta});
   assign hard_s = $signed({2'b00, cfg.hard_delta});
   assign buzz_on = alarm_ff & blevel_ff;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      stop_in      = stop_ff;
      phase_in     = phase_ff;
      duty_l_in    = duty_l_ff;
      duty_r_in    = duty_r_ff;
      bias_in      = bias_ff;
      obst_in      = obst_ff;
      alarm_in     = alarm_ff;
      blevel_in    = blevel_ff;
      bcount_in    = bcount_ff;
      dir_in       = dir_ff;
      pins_in      = pins_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      mod_in       = mod_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      lim_in       = lim_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      left_s       = base_s;
      right_s      = base_s;

      unique case (state_ff)
         // Take the next command
         S_IDLE: begin
            if (q_out.valid) begin
               cmd_in  = q_out.head;
               stop_in = 1'b0;
               unique case (q_out.head.kind)
                  CMD_TICK: state_in = S_SUM;
                  CMD_LINE: state_in = S_LINE;
                  CMD_OBST: state_in = S_OBST;
                  default:  state_in = S_DONE;
               endcase
            end
         end

         // Line update, ignored while blocked
         S_LINE: begin
            state_in = S_DONE;
            if (!obst_ff) begin
               if (cmd_ff.line_code == CODE_LEFT_HARD ||
                   cmd_ff.line_code == CODE_LEFT_SOFT) begin
                  bias_in = BIAS_LEFT;
               end
               if (cmd_ff.line_code == CODE_RIGHT_HARD ||
                   cmd_ff.line_code == CODE_RIGHT_SOFT) begin
                  bias_in = BIAS_RIGHT;
               end
               unique case (cmd_ff.line_code)
                  CODE_LEFT_SOFT: begin
                     left_s  = base_s - soft_s;
                     right_s = base_s + soft_s;
                  end
                  CODE_RIGHT_SOFT: begin
                     left_s  = base_s + soft_s;
                     right_s = base_s - soft_s;
                  end
                  CODE_LEFT_HARD: begin
                     left_s  = base_s - hard_s;
                     right_s = base_s + hard_s;
                  end
                  CODE_RIGHT_HARD: begin
                     left_s  = base_s + hard_s;
                     right_s = base_s - hard_s;
                  end
                  CODE_GAP: begin
                     if (bias_ff == BIAS_LEFT) begin
                        left_s  = base_s - soft_s;
                        right_s = base_s + soft_s;
                     end else if (bias_ff == BIAS_RIGHT) begin
                        left_s  = base_s + soft_s;
                        right_s = base_s - soft_s;
                     end
                  end
                  CODE_ALL: begin
                     left_s  = base_s >>> 1;
                     right_s = base_s >>> 1;
                  end
                  default: ;
               endcase
               if (cmd_ff.line_code == CODE_LOST) begin
                  duty_l_in = '0;
                  duty_r_in = '0;
                  dir_in    = '0;
                  pins_in   = '0;
                  stop_in   = 1'b1;
               end else begin
                  duty_l_in = clamp_pct(left_s);
                  duty_r_in = clamp_pct(right_s);
                  dir_in    = DIR_REVERSE;
               end
            end
         end

         // Obstacle update: stop and raise the alarm, or clear it
         S_OBST: begin
            state_in = S_DONE;
            obst_in  = cmd_ff.obstacle;
            if (cmd_ff.obstacle) begin
               alarm_in  = 1'b1;
               duty_l_in = '0;
               duty_r_in = '0;
               dir_in    = '0;
               pins_in   = '0;
               stop_in   = 1'b1;
            end else begin
               alarm_in  = 1'b0;
               blevel_in = 1'b0;
               bcount_in = '0;
            end
         end

         // Phase advance; short cases avoid the modulo loop
         S_SUM: begin
            if (cfg.pwm_period_us == '0) begin
               phase_in = '0;
               state_in = S_CMP;
            end else if (sum < period_ext) begin
               mod_in   = 16'(sum);
               state_in = S_THR;
            end else if (sum < period_x2) begin
               mod_in   = 16'(sum - period_ext);
               state_in = S_THR;
            end else begin
               num_in   = sum;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end

         // One remainder bit per cycle
         S_DIV: begin
            rem_in = rem_step;
            num_in = SUM_W'(num_ff << 1);
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               mod_in   = rem_step;
               state_in = S_THR;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end

         // Duty thresholds: phase < d*P/100  <=>  d*P >= 100*(phase+1)
         S_THR: begin
            phase_in  = PHASE_BITS'(phase_lo);
            prod_l_in = 23'(duty_l_ff) * 23'(cfg.pwm_period_us);
            prod_r_in = 23'(duty_r_ff) * 23'(cfg.pwm_period_us);
            lim_in    = (24'(phase_lo) + 24'd1) * 24'(PCT_FULL);
            state_in  = S_CMP;
         end

         // PWM pins and buzzer
         S_CMP: begin
            if (cfg.pwm_period_us == '0) begin
               pins_in = '0;
            end else begin
               pins_in = {({1'b0, prod_r_ff} >= lim_ff), ({1'b0, prod_l_ff} >= lim_ff)};
            end
            if (alarm_ff) begin
               if (bcount_ff == '0) begin
                  blevel_in = ~blevel_ff;
               end
               bcount_in = (bcount_inc >= BUZZ_W'(BUZZ_TOGGLE_TICKS)) ? '0 : bcount_inc;
            end else begin
               blevel_in = 1'b0;
               bcount_in = '0;
            end
            state_in = S_DONE;
         end

         // Deliver the response transaction
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.left_pwm    = pins_ff[0];
               rsp_data_in.right_pwm   = pins_ff[1];
               rsp_data_in.left_in1    = dir_ff[0];
               rsp_data_in.left_in2    = dir_ff[1];
               rsp_data_in.right_in1   = dir_ff[2];
               rsp_data_in.right_in2   = dir_ff[3];
               rsp_data_in.buzzer_pin  = cfg.polarity_flags[POL_BUZZ_HIGH] ?
                                         buzz_on : ~buzz_on;
               rsp_data_in.left_speed  = duty_l_ff;
               rsp_data_in.right_speed = duty_r_ff;
               rsp_data_in.stop_issued = stop_ff;
               rsp_data_in.blocked     = obst_ff;
               state_in                = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stop_ff      <= 1'b0;
         phase_ff     <= '0;
         duty_l_ff    <= '0;
         duty_r_ff    <= '0;
         bias_ff      <= BIAS_NONE;
         obst_ff      <= 1'b0;
         alarm_ff     <= 1'b0;
         blevel_ff    <= 1'b0;
         bcount_ff    <= '0;
         dir_ff       <= '0;
         pins_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stop_ff      <= stop_in;
         phase_ff     <= phase_in;
         duty_l_ff    <= duty_l_in;
         duty_r_ff    <= duty_r_in;
         bias_ff      <= bias_in;
         obst_ff      <= obst_in;
         alarm_ff     <= alarm_in;
         blevel_ff    <= blevel_in;
         bcount_ff    <= bcount_in;
         dir_ff       <= dir_in;
         pins_ff      <= pins_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      mod_ff      <= mod_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      lim_ff      <= lim_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/line_follow_motor_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_motor_controller_unit
// Three-sensor line follower with two-motor PWM, obstacle stop and buzzer.
//
//   Channel | Direction | Handshake        | Payload
//   req_    | in        | valid / stall    | mode, line and obstacle pins
//   rsp_    | out       | valid / stall    | pins, duties, stop, blocked
//   csr_    | in        | valid / ready    | register index, write data
//
// Each request gives one response. After S_IDLE a line or obstacle command passes
// its update state, a tick S_SUM, S_THR and S_CMP (no S_THR with a zero period),
// an idle-mode one none, before S_DONE raises rsp_valid. When phase+tick reaches
// twice the period, the bit-serial modulo unit (S_DIV) runs after S_SUM.
// A 2-entry command queue sits between the front and the back, so requests are
// still taken while a response waits; the front stalls once the queue is full.
// Reset is synchronous and skips the data registers; csr_ready is always high.
// ----------------------------------------------------------------------------
module line_follow_motor_controller_unit #(
   parameter int PHASE_BITS        = 16,
   parameter int BUZZ_TOGGLE_TICKS = 300
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lfmc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lfmc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lfmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lfmc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lfmc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          push;
   cmd_type       push_data;
   logic          queue_full;
   logic          pop;
   queue_out_type q_out;

   assign csr_ready = 1'b1;

   // Register file writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PWM_PERIOD: cfg_in.pwm_period_us  = csr_data;
            CSR_TICK_US:    cfg_in.tick_us        = csr_data;
            CSR_BASE_SPEED: cfg_in.base_speed     = csr_data[6:0];
            CSR_SOFT_DELTA: cfg_in.soft_delta     = csr_data[6:0];
            CSR_HARD_DELTA: cfg_in.hard_delta     = csr_data[6:0];
            CSR_POLARITY:   cfg_in.polarity_flags = csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period_us  <= RST_PWM_PERIOD;
         cfg_ff.tick_us        <= RST_TICK_US;
         cfg_ff.base_speed     <= RST_BASE_SPEED;
         cfg_ff.soft_delta     <= RST_SOFT_DELTA;
         cfg_ff.hard_delta     <= RST_HARD_DELTA;
         cfg_ff.polarity_flags <= RST_POLARITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfmc_front u_front (
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   lfmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .q_out     (q_out)
   );

   lfmc_back #(
      .PHASE_BITS        (PHASE_BITS),
      .BUZZ_TOGGLE_TICKS (BUZZ_TOGGLE_TICKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_out     (q_out),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
